// ===== sv/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the Morse decode table for the key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int TIME_W = 48;
  localparam int REG_W  = 26;
  localparam int CHAR_W = 7;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 2;

  localparam int MESSAGE_LIMIT_DEFAULT = 2048;
  localparam int MAX_MARKS_DEFAULT     = 6;

  localparam logic [REG_W-1:0] DASH_THRESHOLD_RESET = REG_W'(1000000);
  localparam logic [REG_W-1:0] LETTER_GAP_RESET     = REG_W'(2000000);
  localparam logic [REG_W-1:0] DEBOUNCE_TIME_RESET  = REG_W'(30000);

  localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = CHAR_W'(8'h3d);

  // Event kinds on the input tuser.
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DASH_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_LETTER_GAP     = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_TIME  = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0] dash_threshold;
    logic [REG_W-1:0] letter_gap;
    logic [REG_W-1:0] debounce_time;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_GAP  = 2'd0,
    OP_MARK = 2'd1,
    OP_SEND = 2'd2
  } op_t;

  typedef struct packed {
    op_t  op;
    logic dash;
  } qentry_t;

  // Code register value (leading 1 included) to character; 0 means no entry.
  function automatic logic [CHAR_W-1:0] morse_lookup(input logic [5:0] code);
    logic [7:0] c;
    c = 8'h00;
    unique case (code)
      6'd5:  c = "a";
      6'd24: c = "b";
      6'd26: c = "c";
      6'd12: c = "d";
      6'd2:  c = "e";
      6'd18: c = "f";
      6'd14: c = "g";
      6'd16: c = "h";
      6'd4:  c = "i";
      6'd23: c = "j";
      6'd13: c = "k";
      6'd20: c = "l";
      6'd7:  c = "m";
      6'd6:  c = "n";
      6'd15: c = "o";
      6'd22: c = "p";
      6'd29: c = "q";
      6'd10: c = "r";
      6'd8:  c = "s";
      6'd3:  c = "t";
      6'd9:  c = "u";
      6'd17: c = "v";
      6'd11: c = "w";
      6'd25: c = "x";
      6'd27: c = "y";
      6'd28: c = "z";
      6'd63: c = "0";
      6'd47: c = "1";
      6'd39: c = "2";
      6'd35: c = "3";
      6'd33: c = "4";
      6'd32: c = "5";
      6'd48: c = "6";
      6'd56: c = "7";
      6'd60: c = "8";
      6'd62: c = "9";
      default: c = 8'h00;
    endcase
    return c[CHAR_W-1:0];
  endfunction

endpackage

// ===== sv/mkd_front.sv =====
// ----------------------------------------------------------------------------
// mkd_front
// Accepts key events, debounces each kind against its own last time and
// classifies the survivors into letter-gap, mark and send operations.
// ----------------------------------------------------------------------------
module mkd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  mkd_pkg::cfg_t                 cfg,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mkd_pkg::TIME_W-1:0]    time_us,
  input  logic [mkd_pkg::CMD_W-1:0]     cmd,
  input  logic                          queue_full,
  output logic                          push,
  output mkd_pkg::qentry_t              push_entry
);
  import mkd_pkg::*;

  logic [TIME_W-1:0] last_start_time;
  logic [TIME_W-1:0] last_end_time;
  logic [TIME_W-1:0] last_send_time;
  logic              press_active;

  logic [TIME_W-1:0] ref_deb;
  logic [TIME_W-1:0] ref_alt;
  logic [TIME_W-1:0] el_deb;
  logic [TIME_W-1:0] el_alt;
  logic              bounce;
  logic              accept;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  // One subtractor for the debounce interval of the event's own kind, one for
  // the gap (press start) or hold (press end) interval.
  always_comb begin
    unique case (cmd)
      CMD_END:  ref_deb = last_end_time;
      CMD_SEND: ref_deb = last_send_time;
      default:  ref_deb = last_start_time;
    endcase
    ref_alt = (cmd == CMD_END) ? last_start_time : last_end_time;
    el_deb  = time_us - ref_deb;
    el_alt  = time_us - ref_alt;
    bounce  = el_deb < TIME_W'(cfg.debounce_time);
  end

  always_comb begin
    push            = 1'b0;
    push_entry.op   = OP_GAP;
    push_entry.dash = el_alt > TIME_W'(cfg.dash_threshold);
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          push          = !bounce && (el_alt > TIME_W'(cfg.letter_gap));
          push_entry.op = OP_GAP;
        end
        CMD_END: begin
          push          = !bounce;
          push_entry.op = OP_MARK;
        end
        CMD_SEND: begin
          push          = !bounce && !press_active;
          push_entry.op = OP_SEND;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_start_time <= '0;
      last_end_time   <= '0;
      last_send_time  <= '0;
      press_active    <= 1'b0;
    end else if (accept && !bounce) begin
      unique case (cmd)
        CMD_START: begin
          last_start_time <= time_us;
          press_active    <= 1'b1;
        end
        CMD_END: begin
          last_end_time <= time_us;
          press_active  <= 1'b0;
        end
        CMD_SEND: begin
          if (!press_active) begin
            last_send_time <= time_us;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mkd_queue.sv =====
// ----------------------------------------------------------------------------
// mkd_queue
// Two-entry queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module mkd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mkd_pkg::qentry_t  push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output mkd_pkg::qentry_t  head
);
  import mkd_pkg::*;

  qentry_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/mkd_back.sv =====
// ----------------------------------------------------------------------------
// mkd_back
// Builds the pending Morse code, closes letters, decodes them and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module mkd_back #(
  parameter int MESSAGE_LIMIT = mkd_pkg::MESSAGE_LIMIT_DEFAULT,
  parameter int MAX_MARKS     = mkd_pkg::MAX_MARKS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        not_empty,
  input  mkd_pkg::qentry_t            head,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mkd_pkg::CHAR_W-1:0]  letter,
  output logic                        has_letter,
  output logic                        message_end
);
  import mkd_pkg::*;

  localparam int CODE_W = MAX_MARKS + 1;
  localparam int LEN_W  = $clog2(MAX_MARKS + 1);
  localparam int CNT_W  = $clog2(MESSAGE_LIMIT + 1);

  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              code_overflow;
  logic [CNT_W-1:0]  element_count;

  logic              pending;
  logic [15:0]       code_ext;
  logic [CHAR_W-1:0] table_char;
  logic [CHAR_W-1:0] decoded;
  logic [CNT_W-1:0]  count_inc;
  logic              out_free;
  logic              emit;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = not_empty && out_free;
  assign pending  = (code_length != '0) || code_overflow;

  always_comb begin
    code_ext   = 16'(code_bits);
    table_char = morse_lookup(code_ext[5:0]);
    if (!code_overflow && (code_ext[15:6] == '0) && (table_char != '0)) begin
      decoded = table_char;
    end else begin
      decoded = UNKNOWN_CHAR;
    end
    count_inc = (element_count < CNT_W'(MESSAGE_LIMIT)) ? element_count + 1'b1
                                                        : element_count;
    // A popped send always produces a transaction; a gap only when it closes a letter.
    emit = pop && ((head.op == OP_SEND) || ((head.op == OP_GAP) && pending));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits     <= CODE_W'(1);
      code_length   <= '0;
      code_overflow <= 1'b0;
      element_count <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      m_tvalid <= emit || (m_tvalid && !m_tready);
      if (pop) begin
        unique case (head.op)
          OP_GAP: begin
            if (pending) begin
              letter        <= decoded;
              has_letter    <= 1'b1;
              message_end   <= 1'b0;
              code_bits     <= CODE_W'(1);
              code_length   <= '0;
              code_overflow <= 1'b0;
              element_count <= count_inc;
            end
          end
          OP_MARK: begin
            // Marks are dropped once the element count reaches two below the message limit.
            if (element_count < CNT_W'(MESSAGE_LIMIT - 2)) begin
              if (code_length < LEN_W'(MAX_MARKS)) begin
                code_bits   <= {code_bits[CODE_W-2:0], head.dash};
                code_length <= code_length + 1'b1;
              end else begin
                code_overflow <= 1'b1;
              end
              element_count <= count_inc;
            end
          end
          OP_SEND: begin
            letter        <= pending ? decoded : '0;
            has_letter    <= pending;
            message_end   <= 1'b1;
            code_bits     <= CODE_W'(1);
            code_length   <= '0;
            code_overflow <= 1'b0;
            element_count <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/morse_key_decoder_top.sv =====
// ----------------------------------------------------------------------------
// morse_key_decoder_top
// Morse key decoder: timestamped key events in, decoded characters out.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the event kind (press start, press end, send),
// tdata the 48-bit microsecond timestamp. Output stream: tdata carries the
// character, tuser is set when a character is present, and tlast marks the
// result of an accepted send, which closes the message.
// The configuration port writes the dash threshold, letter gap and debounce
// time; writes take effect at the next clock edge.
// One event is accepted every clock cycle while the queue is not full. The front
// part debounces the event and classifies it in the accepting cycle; the
// operation is queued, and the result, if any, is registered in the output
// register. Events other than sends that close no letter produce no output transaction.
// When the receiver stalls, the output register holds its result and the
// two-entry queue between the classifier and the decoder absorbs further
// operations; tready drops only when that queue is full.
// Reset clears all timestamps, the pending code and the message element count,
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module morse_key_decoder_top #(
  parameter int MESSAGE_LIMIT = mkd_pkg::MESSAGE_LIMIT_DEFAULT,
  parameter int MAX_MARKS     = mkd_pkg::MAX_MARKS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mkd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mkd_pkg::REG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,   // time_us[47:0]
  input  logic [mkd_pkg::CMD_W-1:0]   s_tuser,   // cmd[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // letter[6:0], zero [7]
  output logic                        m_tuser,   // has_letter
  output logic                        m_tlast    // message_end
);
  import mkd_pkg::*;

  cfg_t              cfg;
  logic              push;
  qentry_t           push_entry;
  logic              pop;
  logic              queue_full;
  logic              not_empty;
  qentry_t           head;
  logic [CHAR_W-1:0] letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dash_threshold <= DASH_THRESHOLD_RESET;
      cfg.letter_gap     <= LETTER_GAP_RESET;
      cfg.debounce_time  <= DEBOUNCE_TIME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DASH_THRESHOLD: cfg.dash_threshold <= cfg_data;
        REG_LETTER_GAP:     cfg.letter_gap     <= cfg_data;
        REG_DEBOUNCE_TIME:  cfg.debounce_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  mkd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .time_us    (s_tdata),
    .cmd        (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mkd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (not_empty),
    .head       (head)
  );

  mkd_back #(
    .MESSAGE_LIMIT (MESSAGE_LIMIT),
    .MAX_MARKS     (MAX_MARKS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .letter      (letter),
    .has_letter  (m_tuser),
    .message_end (m_tlast)
  );

  assign m_tdata = {1'b0, letter};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse key decoder testbench
// Key events with microsecond timestamps go into the decoder. A model of the
// decoder inside the bench predicts each decoded character, and every output
// transaction is checked against it. Directed events come first. They cover
// the debounce and threshold edges, a send while the key is down, an empty
// send, an overlong code and a wrap of the timer. Random words follow under
// several register settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT         = mkd_pkg::MESSAGE_LIMIT_DEFAULT;
  localparam int MARKS         = mkd_pkg::MAX_MARKS_DEFAULT;
  localparam logic [mkd_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam logic [mkd_pkg::REG_W-1:0] REG_MAX  = 26'h3FF_FFFF;

  typedef enum logic {ENTRY_EVENT, ENTRY_CONFIG} entry_kind_t;

  typedef struct packed {
    entry_kind_t                 kind;
    logic [mkd_pkg::CMD_W-1:0]   cmd;
    logic [47:0]                 stamp;
    logic [mkd_pkg::IDX_W-1:0]   index;
    logic [mkd_pkg::REG_W-1:0]   value;
  } stim_entry_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       has_letter;
    logic       msg_end;
  } key_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [mkd_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [mkd_pkg::REG_W-1:0]   cfg_data = '0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [47:0]                 s_tdata = '0;
  logic [mkd_pkg::CMD_W-1:0]   s_tuser = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [7:0]                  m_tdata;
  logic                        m_tuser;
  logic                        m_tlast;

  morse_key_decoder_top #(
    .MESSAGE_LIMIT(LIMIT),
    .MAX_MARKS(MARKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Dots and dashes of each character, in the order of the charset string.
  string morse_pattern [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };
  string charset = "abcdefghijklmnopqrstuvwxyz0123456789";

  // Decoder model state.
  logic [mkd_pkg::REG_W-1:0] cfg_dash     = mkd_pkg::DASH_THRESHOLD_RESET;
  logic [mkd_pkg::REG_W-1:0] cfg_gap      = mkd_pkg::LETTER_GAP_RESET;
  logic [mkd_pkg::REG_W-1:0] cfg_debounce = mkd_pkg::DEBOUNCE_TIME_RESET;
  logic [6:0]  key_code     = 7'd1;
  int unsigned key_len      = 0;
  logic        key_overflow = 1'b0;
  logic [47:0] t_last_start = '0;
  logic [47:0] t_last_end   = '0;
  logic [47:0] t_last_send  = '0;
  logic        key_down     = 1'b0;
  int          msg_elems    = 0;

  key_result_t letters_due[$];
  stim_entry_t key_script[$];
  stim_entry_t cur;

  // Stimulus generator state: its own view of time and of the registers.
  logic [47:0] gen_now = '0;
  int unsigned g_dash  = mkd_pkg::DASH_THRESHOLD_RESET;
  int unsigned g_gap   = mkd_pkg::LETTER_GAP_RESET;
  int unsigned g_deb   = mkd_pkg::DEBOUNCE_TIME_RESET;
  int script_events = 0;
  int live_events   = 0;

  int  taken_count  = 0;
  bit  in_taken     = 1'b0;
  int  quiet_cycles = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  int  errors       = 0;
  logic drv_valid;
  logic drv_write;
  logic calm;
  key_result_t want;

  assign calm = (taken_count >= 600) && (taken_count < 800);

  function automatic logic [6:0] morse_char(input logic [6:0] code, input logic ovf);
    logic [6:0] ch;
    logic [6:0] pat_code;
    int i;
    int j;
    ch = mkd_pkg::UNKNOWN_CHAR;
    if (!ovf) begin
      for (i = 0; i < 36; i++) begin
        pat_code = 7'd1;
        for (j = 0; j < morse_pattern[i].len(); j++)
          pat_code = {pat_code[5:0], morse_pattern[i][j] == "-"};
        if (pat_code == code) ch = 7'(charset[i]);
      end
    end
    return ch;
  endfunction

  task automatic decode_key_event(input logic [1:0] cmd, input logic [47:0] stamp);
    logic [47:0] since_start;
    logic [47:0] since_end;
    logic [47:0] since_send;
    logic        pending;
    key_result_t res;
    since_start = stamp - t_last_start;
    since_end   = stamp - t_last_end;
    since_send  = stamp - t_last_send;
    pending     = (key_len != 0) || key_overflow;
    res         = '0;
    case (cmd)
      mkd_pkg::CMD_START: begin
        if (since_start >= 48'(cfg_debounce)) begin
          t_last_start = stamp;
          key_down = 1'b1;
          if (since_end > 48'(cfg_gap) && pending) begin
            res.letter = morse_char(key_code, key_overflow);
            res.has_letter = 1'b1;
            letters_due.push_back(res);
            key_code = 7'd1;
            key_len = 0;
            key_overflow = 1'b0;
            if (msg_elems < LIMIT) msg_elems++;
          end
        end
      end
      mkd_pkg::CMD_END: begin
        if (since_end >= 48'(cfg_debounce)) begin
          t_last_end = stamp;
          key_down = 1'b0;
          // Near the message limit the timing still updates but the mark is lost.
          if (msg_elems < LIMIT - 2) begin
            if (key_len < MARKS) begin
              key_code = {key_code[5:0], since_start > 48'(cfg_dash)};
              key_len++;
            end else begin
              key_overflow = 1'b1;
            end
            if (msg_elems < LIMIT) msg_elems++;
          end
        end
      end
      mkd_pkg::CMD_SEND: begin
        if (!key_down && since_send >= 48'(cfg_debounce)) begin
          t_last_send = stamp;
          if (pending) begin
            res.letter = morse_char(key_code, key_overflow);
            res.has_letter = 1'b1;
          end
          res.msg_end = 1'b1;
          letters_due.push_back(res);
          key_code = 7'd1;
          key_len = 0;
          key_overflow = 1'b0;
          msg_elems = 0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned span(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    if (hi <= lo) return lo;
    r = $urandom_range(7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned reach(input int unsigned x);
    return x / 2 + 1000;
  endfunction

  function automatic int unsigned larger(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

  task automatic add_event(input logic [1:0] cmd, input int unsigned delta);
    stim_entry_t e;
    gen_now = gen_now + 48'(delta);
    e.kind  = ENTRY_EVENT;
    e.cmd   = cmd;
    e.stamp = gen_now;
    e.index = '0;
    e.value = '0;
    key_script.push_back(e);
    script_events++;
    if (cmd != CMD_NONE) live_events++;
  endtask

  task automatic add_at(input logic [1:0] cmd, input logic [47:0] stamp);
    gen_now = stamp;
    add_event(cmd, 0);
  endtask

  task automatic add_config(input logic [1:0] idx, input logic [25:0] value);
    stim_entry_t e;
    e.kind  = ENTRY_CONFIG;
    e.cmd   = CMD_NONE;
    e.stamp = '0;
    e.index = idx;
    e.value = value;
    key_script.push_back(e);
    case (idx)
      mkd_pkg::REG_DASH_THRESHOLD: g_dash = value;
      mkd_pkg::REG_LETTER_GAP:     g_gap  = value;
      default:                     g_deb  = value;
    endcase
  endtask

  // Mostly well-formed words of table characters, with some unknown or
  // overlong codes, presses broken in various ways and plain noise.
  task automatic gen_random(input int count);
    int goal;
    int letters;
    int n;
    int i;
    int unsigned off;
    int unsigned hold;
    string marks;
    goal = live_events + count;
    while (live_events < goal) begin
      case ($urandom_range(9))
        0: begin
          if ($urandom_range(3) == 0) gen_now = 48'({$urandom(), $urandom()});
          add_event(2'($urandom_range(3)), span(0, g_deb + 1000));
        end
        1: begin
          case ($urandom_range(2))
            0: begin
              add_event(mkd_pkg::CMD_START, span(g_deb, g_gap + reach(g_gap)));
              add_event(mkd_pkg::CMD_SEND, span(0, g_dash));
              add_event(mkd_pkg::CMD_END, span(g_deb, g_dash + reach(g_dash)));
            end
            1: add_event(mkd_pkg::CMD_END, span(0, g_deb + g_dash));
            default: begin
              add_event(mkd_pkg::CMD_START, span(0, g_deb));
              add_event(mkd_pkg::CMD_START, span(0, 2 * g_deb));
            end
          endcase
        end
        default: begin
          letters = $urandom_range(4, 1);
          for (n = 0; n < letters; n++) begin
            if ($urandom_range(4) == 0) begin
              marks = "";
              repeat ($urandom_range(8, 1)) begin
                if ($urandom_range(1)) marks = {marks, "-"};
                else marks = {marks, "."};
              end
            end else begin
              marks = morse_pattern[$urandom_range(35)];
            end
            for (i = 0; i < marks.len(); i++) begin
              if (i == 0) off = span(larger(g_gap + 1, g_deb), g_gap + 1 + reach(g_gap));
              else off = span(g_deb, g_gap);
              add_event(mkd_pkg::CMD_START, off);
              if (marks[i] == "-")
                hold = span(larger(g_dash + 1, g_deb), g_dash + 1 + reach(g_dash));
              else
                hold = span(g_deb, g_dash);
              add_event(mkd_pkg::CMD_END, hold);
            end
          end
          if ($urandom_range(3) != 0)
            add_event(mkd_pkg::CMD_SEND, span(g_deb, g_gap + reach(g_gap)));
        end
      endcase
    end
  endtask

  // Output check first, then prediction: a result never belongs to the event
  // accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (letters_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result: expected none, actual data %h user %b last %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = letters_due.pop_front();
          if (m_tdata !== {1'b0, want.letter}) begin
            errors++;
            $display("%0t ns: letter mismatch: expected %h, actual %h",
                     $time, {1'b0, want.letter}, m_tdata);
          end
          if (m_tuser !== want.has_letter) begin
            errors++;
            $display("%0t ns: has_letter mismatch: expected %b, actual %b",
                     $time, want.has_letter, m_tuser);
          end
          if (m_tlast !== want.msg_end) begin
            errors++;
            $display("%0t ns: message_end mismatch: expected %b, actual %b",
                     $time, want.msg_end, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        decode_key_event(s_tuser, s_tdata);
        in_taken = 1'b1;
        taken_count++;
      end
    end
  end

  // Register writes wait until every result has come out and the pipeline
  // has had time to empty of events that close no letter.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_write <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      drv_valid = 1'b0;
      drv_write = 1'b0;
      if (key_script.size() != 0) begin
        if (key_script[0].kind == ENTRY_EVENT) begin
          if (calm || $urandom_range(99) >= 10) begin
            cur = key_script.pop_front();
            drv_valid = 1'b1;
            s_tuser <= cur.cmd;
            s_tdata <= cur.stamp;
          end
        end else if (letters_due.size() != 0) begin
          quiet_cycles = 0;
        end else if (quiet_cycles < SETTLE_CYCLES) begin
          quiet_cycles++;
        end else begin
          quiet_cycles = 0;
          cur = key_script.pop_front();
          drv_write = 1'b1;
          cfg_index <= cur.index;
          cfg_data <= cur.value;
          case (cur.index)
            mkd_pkg::REG_DASH_THRESHOLD: cfg_dash     = cur.value;
            mkd_pkg::REG_LETTER_GAP:     cfg_gap      = cur.value;
            default:                     cfg_debounce = cur.value;
          endcase
        end
      end
      s_tvalid <= drv_valid;
      cfg_write <= drv_write;
    end
  end

  // Receiver: random stalls, one long hold-off that backs the decoder up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && taken_count >= 150) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 10);
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int k;

    // Directed events under the reset register values.
    add_at(mkd_pkg::CMD_START, 48'd0);         // inside the debounce window after reset
    add_at(mkd_pkg::CMD_END, 48'd29999);
    add_at(mkd_pkg::CMD_SEND, 48'd100);
    add_at(CMD_NONE, 48'd200);
    add_at(mkd_pkg::CMD_START, 48'd30000);     // exactly the debounce time
    add_at(mkd_pkg::CMD_END, 48'd1030000);     // hold equal to the threshold is a dot
    add_at(mkd_pkg::CMD_START, 48'd3030001);   // gap one past the limit closes the letter
    add_at(mkd_pkg::CMD_END, 48'd4030002);     // dash
    add_at(mkd_pkg::CMD_START, 48'd4040000);
    add_at(mkd_pkg::CMD_SEND, 48'd4050000);    // key is down, so the send is dropped
    add_at(mkd_pkg::CMD_END, 48'd4070000);
    add_at(mkd_pkg::CMD_SEND, 48'd4100000);
    add_at(mkd_pkg::CMD_SEND, 48'd4110000);
    add_at(mkd_pkg::CMD_SEND, 48'd4200000);    // nothing pending
    for (k = 0; k < 7; k++)                    // press ends alone, one mark too many
      add_at(mkd_pkg::CMD_END, 48'd5000000 + 48'(k * 40000));
    add_at(mkd_pkg::CMD_SEND, 48'd5300000);
    add_at(mkd_pkg::CMD_END, 48'hFFFF_FFFF_FFFF);
    add_at(mkd_pkg::CMD_START, 48'd2000000);   // measured across the timer wrap
    add_at(mkd_pkg::CMD_END, 48'd2500000);
    gen_random(250);

    add_config(mkd_pkg::REG_DASH_THRESHOLD, 26'd1000);
    add_config(mkd_pkg::REG_LETTER_GAP, 26'd5000);
    add_config(mkd_pkg::REG_DEBOUNCE_TIME, 26'd0);
    gen_random(200);

    add_config(mkd_pkg::REG_DASH_THRESHOLD, REG_MAX);
    add_config(mkd_pkg::REG_LETTER_GAP, REG_MAX);
    add_config(mkd_pkg::REG_DEBOUNCE_TIME, REG_MAX);
    gen_now = 48'hFFFF_FFFF_FFFF - 48'd200000000;
    gen_random(150);

    add_config(mkd_pkg::REG_DASH_THRESHOLD, 26'd0);
    add_config(mkd_pkg::REG_LETTER_GAP, 26'd0);
    add_config(mkd_pkg::REG_DEBOUNCE_TIME, 26'd1);
    gen_random(150);

    add_config(mkd_pkg::REG_DASH_THRESHOLD, 26'($urandom()));
    add_config(mkd_pkg::REG_LETTER_GAP, 26'($urandom()));
    add_config(mkd_pkg::REG_DEBOUNCE_TIME, 26'($urandom_range(200000)));
    gen_random(250);

    add_config(mkd_pkg::REG_DASH_THRESHOLD, 26'd500);
    add_config(mkd_pkg::REG_LETTER_GAP, 26'd100000);
    add_config(mkd_pkg::REG_DEBOUNCE_TIME, 26'd10);
    gen_random(50);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_count < script_events || letters_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== morse_key_decoder_top.f =====
sv/mkd_pkg.sv
sv/mkd_front.sv
sv/mkd_queue.sv
sv/mkd_back.sv
sv/morse_key_decoder_top.sv
dv/tb.sv
